// File: sv/smi_pkg.sv
// smi_pkg: types and constants for the shape morph interpolator.
// No dependencies.
`timescale 1ns / 1ps
package smi_pkg;

    typedef struct packed {
        logic [9:0]  frame_index;
        logic        first_vertex;
        logic [10:0] start_x;
        logic [10:0] start_y;
        logic [10:0] end_x;
        logic [10:0] end_y;
    } smi_in_t;

    typedef struct packed {
        logic signed [11:0] cur_x;
        logic signed [11:0] cur_y;
        logic               saturated;
    } smi_out_t;

    localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] REG_EASE_MODE   = 2'd1;
    localparam logic [1:0] REG_INTERP_MODE = 2'd2;

    localparam logic [1:0] EASE_LINEAR = 2'd0;
    localparam logic [1:0] EASE_IN     = 2'd1;
    localparam logic [1:0] EASE_OUT    = 2'd2;

    localparam logic signed [31:0] K_Q30 = 32'sd652032874;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_EASE_INIT,
        ST_EASE_RUN,
        ST_EASE_DONE,
        ST_POLAR_S_INIT,
        ST_POLAR_RUN,
        ST_POLAR_S_DONE,
        ST_POLAR_E_INIT,
        ST_POLAR_E_DONE,
        ST_BLEND,
        ST_ROT_INIT,
        ST_ROT_DONE,
        ST_OUT
    } smi_state_t;

    typedef enum logic [1:0] {
        CORD_IDLE,
        CORD_KMUL,
        CORD_RUN,
        CORD_FIN
    } smi_cord_state_t;

    // Arctangent steps as fractions of a 2^32 turn
    function automatic logic [31:0] atan_turn32(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: sv/smi_cordic.sv
// smi_cordic: shared iterative CORDIC, vectoring and rotation modes.
// Depends on smi_pkg. One micro-rotation per cycle; rotation mode applies the gain in its KMUL state.
`timescale 1ns / 1ps
module smi_cordic #(
    parameter int ANGLE_BITS = 16,
    parameter int VW         = 36
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  vectoring,
    input  logic signed [VW-1:0]  x_in,
    input  logic signed [VW-1:0]  y_in,
    input  logic [ANGLE_BITS-1:0] ang_in,
    output logic                  done,
    output logic signed [VW-1:0]  x_out,
    output logic signed [VW-1:0]  y_out,
    output logic [ANGLE_BITS-1:0] ang_out
);
    import smi_pkg::*;

    localparam int ITERS = (ANGLE_BITS < 24) ? ANGLE_BITS : 24;
    localparam int IW    = $clog2(ITERS + 1);
    localparam int ZW    = ANGLE_BITS + 2;
    localparam int SH    = 32 - ANGLE_BITS;
    localparam int PW    = VW + 32;
    localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (ANGLE_BITS - 1);
    localparam logic signed [ZW-1:0] QTR  = ZW'(1) <<< (ANGLE_BITS - 2);
    localparam logic signed [ZW-1:0] TURN = ZW'(1) <<< ANGLE_BITS;

    smi_cord_state_t st_reg, st_next;
    logic signed [VW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [IW-1:0]        i_reg, i_next;
    logic                 vec_reg, vec_next;
    logic                 zero_reg, zero_next;

    logic signed [PW-1:0] prod;
    logic signed [VW-1:0] xs, ys, kx;
    logic [31:0]          at_raw;
    logic signed [ZW-1:0] at_step;
    logic signed [ZW-1:0] za;
    logic                 dir_pos;

    assign prod    = PW'(x_reg) * PW'(K_Q30);
    assign kx      = VW'(prod >>> 30);
    assign xs      = x_reg >>> i_reg;
    assign ys      = y_reg >>> i_reg;
    assign at_raw  = atan_turn32(5'(i_reg));
    assign at_step = ZW'((at_raw + (32'd1 << (SH - 1))) >> SH);
    assign dir_pos = vec_reg ? (y_reg > 0) : (z_reg >= 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= CORD_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        i_reg    <= i_next;
        vec_reg  <= vec_next;
        zero_reg <= zero_next;
    end

    always_comb
    begin
        st_next   = st_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        vec_next  = vec_reg;
        zero_next = zero_reg;
        done      = 1'b0;
        za        = '0;
        unique case (st_reg)
            CORD_IDLE:
            begin
                if (start)
                begin
                    vec_next  = vectoring;
                    i_next    = '0;
                    zero_next = 1'b0;
                    if (vectoring)
                    begin
                        zero_next = (x_in == 0) && (y_in == 0);
                        if (x_in < 0)
                        begin
                            x_next = -x_in;
                            y_next = -y_in;
                            z_next = HALF;
                        end
                        else
                        begin
                            x_next = x_in;
                            y_next = y_in;
                            z_next = '0;
                        end
                        st_next = CORD_RUN;
                    end
                    else
                    begin
                        x_next  = x_in;
                        y_next  = '0;
                        z_next  = ZW'(ang_in);
                        st_next = CORD_KMUL;
                    end
                end
            end
            CORD_KMUL:
            begin
                za = z_reg;
                if (z_reg >= QTR && z_reg < 3 * QTR)
                begin
                    x_next = -kx;
                    za     = z_reg - HALF;
                end
                else
                begin
                    x_next = kx;
                end
                if (za >= HALF)
                begin
                    za = za - TURN;
                end
                z_next  = za;
                st_next = CORD_RUN;
            end
            CORD_RUN:
            begin
                if (dir_pos == vec_reg)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                end
                if (dir_pos)
                begin
                    z_next = vec_reg ? z_reg + at_step : z_reg - at_step;
                end
                else
                begin
                    z_next = vec_reg ? z_reg - at_step : z_reg + at_step;
                end
                i_next = i_reg + 1'b1;
                if (i_reg == IW'(ITERS - 1))
                begin
                    st_next = CORD_FIN;
                end
            end
            CORD_FIN:
            begin
                done    = 1'b1;
                st_next = CORD_IDLE;
            end
            default:
            begin
                st_next = CORD_IDLE;
            end
        endcase
    end

    // vectoring radius takes the gain in the finish cycle
    assign x_out   = (vec_reg) ? (zero_reg ? '0 : kx) : x_reg;
    assign y_out   = y_reg;
    assign ang_out = zero_reg ? '0 : z_reg[ANGLE_BITS-1:0];

endmodule

// File: sv/shape_morph_interpolator.sv
// shape_morph_interpolator: top level, sequencer, divider and blend datapath.
// Depends on smi_pkg and smi_cordic.
`timescale 1ns / 1ps
//  channel  | direction | handshake          | payload
//  in       | input     | in_valid/in_ready  | smi_in_t
//  out      | output    | out_valid/out_ready| smi_out_t
//  cfg      | input     | cfg_we             | cfg_index, cfg_data
//
// One item at a time. Blend division is restoring, one quotient bit a cycle.
// Vectoring and rotation passes run on one shared CORDIC unit. Linear mode
// blends directly, after a rotation pass when easing; vector mode adds two
// vectoring passes and a rotation pass.
// Output register frees the unit: in_ready rises as soon as the result is
// loaded; a result still held in the output stalls the next item at its end.
// Reset clears state, config (frame_count 20) and the output valid.
module shape_morph_interpolator #(
    parameter int ANGLE_BITS = 16,
    parameter int BLEND_BITS = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  smi_pkg::smi_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output smi_pkg::smi_out_t out_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [9:0]       cfg_data
);
    import smi_pkg::*;

    localparam int FRAC = 12;
    localparam int VW   = 36;
    localparam int FW   = BLEND_BITS + 1;
    localparam int QW   = BLEND_BITS + 10;
    localparam int DCW  = $clog2(QW + 1);
    localparam int AW   = ANGLE_BITS + 1;
    localparam logic [FW-1:0] ONE = FW'(1) << BLEND_BITS;
    localparam logic signed [AW:0] HALF_S = (AW+1)'(1) <<< (ANGLE_BITS - 1);
    localparam logic signed [AW:0] TURN_S = (AW+1)'(1) <<< ANGLE_BITS;

    // configuration
    logic [9:0] frame_count_reg;
    logic [1:0] ease_mode_reg;
    logic       interp_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= 10'd20;
            ease_mode_reg   <= EASE_LINEAR;
            interp_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_COUNT: frame_count_reg <= cfg_data;
                REG_EASE_MODE:   ease_mode_reg   <= cfg_data[1:0];
                REG_INTERP_MODE: interp_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    smi_state_t st_reg, st_next;
    smi_in_t    item_reg, item_next;
    logic [FW-1:0] f_reg, f_next;
    logic [QW-1:0] q_reg, q_next;
    logic [10:0]   rem_reg, rem_next;
    logic [DCW-1:0] dc_reg, dc_next;
    logic signed [VW-1:0] rs_reg, rs_next;
    logic [ANGLE_BITS-1:0] ts_reg, ts_next;
    logic signed [VW-1:0] re_reg, re_next;
    logic [ANGLE_BITS-1:0] te_reg, te_next;
    logic [10:0] pss_x_reg, pss_y_reg, pse_x_reg, pse_y_reg;
    logic signed [11:0] lo_x_reg, lo_y_reg;
    logic pv_we;
    smi_out_t res, out_reg;
    logic out_valid_reg;

    // shared CORDIC
    logic cs, cvec, cdone;
    logic signed [VW-1:0] cxi, cyi, cxo, cyo;
    logic [ANGLE_BITS-1:0] cai, cao;

    smi_cordic #(.ANGLE_BITS(ANGLE_BITS), .VW(VW)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cs), .vectoring(cvec),
        .x_in(cxi), .y_in(cyi), .ang_in(cai), .done(cdone),
        .x_out(cxo), .y_out(cyo), .ang_out(cao)
    );

    logic [9:0]  fc_eff;
    logic [11:0] rem_sh;
    logic signed [VW-1:0] dsx, dsy, dex, dey;
    logic signed [AW:0] dang;
    logic signed [AW+FW+1:0] fd;
    logic signed [VW+FW+1:0] rb;
    logic signed [VW-1:0] r_blend;
    logic [ANGLE_BITS-1:0] th;
    logic signed [VW-1:0] sx, sy;
    logic signed [VW-1:0] fx, fy, lx, ly;
    logic signed [VW-1:0] fe;
    logic [BLEND_BITS+ANGLE_BITS-2:0] ease_wide;
    logic [ANGLE_BITS-1:0] ease_ang;

    assign fc_eff = (frame_count_reg == 10'd0) ? 10'd1 : frame_count_reg;
    assign rem_sh = {rem_reg, q_reg[QW-1]};
    assign dsx = VW'($signed({1'b0, item_reg.start_x}) - $signed({1'b0, pss_x_reg})) <<< FRAC;
    assign dsy = VW'($signed({1'b0, item_reg.start_y}) - $signed({1'b0, pss_y_reg})) <<< FRAC;
    assign dex = VW'($signed({1'b0, item_reg.end_x}) - $signed({1'b0, pse_x_reg})) <<< FRAC;
    assign dey = VW'($signed({1'b0, item_reg.end_y}) - $signed({1'b0, pse_y_reg})) <<< FRAC;
    // quarter-turn scaled by t, kept full width before the shift down
    assign ease_wide = {q_reg[BLEND_BITS:0], {(ANGLE_BITS-2){1'b0}}};
    assign ease_ang  = ANGLE_BITS'(ease_wide >> BLEND_BITS);

    // blend of angle and radius from latched start and end polar
    always_comb
    begin
        dang = $signed({2'b0, te_reg}) - $signed({2'b0, ts_reg});
        if (dang > HALF_S)
        begin
            dang = dang - TURN_S;
        end
        else if (dang < -HALF_S)
        begin
            dang = dang + TURN_S;
        end
        fd = $signed({1'b0, f_reg}) * dang;
        th = ts_reg + ANGLE_BITS'(fd >>> BLEND_BITS);
        rb = $signed({1'b0, ONE - f_reg}) * rs_reg + $signed({1'b0, f_reg}) * re_reg;
        r_blend = VW'(rb >>> BLEND_BITS);
    end

    // linear blend and vector accumulate
    always_comb
    begin
        res = '0;
        lx = VW'(((ONE - f_reg) * item_reg.start_x + f_reg * item_reg.end_x) >> BLEND_BITS);
        ly = VW'(((ONE - f_reg) * item_reg.start_y + f_reg * item_reg.end_y) >> BLEND_BITS);
        sx = (VW'(lo_x_reg) <<< FRAC) + cxo;
        sy = (VW'(lo_y_reg) <<< FRAC) + cyo;
        fx = (sx < 0) ? -((-sx) >>> FRAC) : (sx >>> FRAC);
        fy = (sy < 0) ? -((-sy) >>> FRAC) : (sy >>> FRAC);
        if (interp_mode_reg && !item_reg.first_vertex)
        begin
            res.cur_x = (fx > 2047) ? 12'sd2047 : (fx < -2048) ? -12'sd2048 : 12'(fx);
            res.cur_y = (fy > 2047) ? 12'sd2047 : (fy < -2048) ? -12'sd2048 : 12'(fy);
            res.saturated = (fx > 2047) || (fx < -2048) || (fy > 2047) || (fy < -2048);
        end
        else
        begin
            res.cur_x = 12'(lx);
            res.cur_y = 12'(ly);
        end
    end

    // ease result from rotation of ONE
    always_comb
    begin
        fe = '0;
        if (ease_mode_reg == EASE_IN)
        begin
            fe = VW'(ONE) - (cxo >>> FRAC);
        end
        else
        begin
            fe = cyo >>> FRAC;
        end
        if (fe < 0)
        begin
            fe = '0;
        end
        else if (fe > VW'(ONE))
        begin
            fe = VW'(ONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pss_x_reg <= '0; pss_y_reg <= '0; pse_x_reg <= '0; pse_y_reg <= '0;
            lo_x_reg  <= '0; lo_y_reg  <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (pv_we)
            begin
                out_valid_reg <= 1'b1;
                pss_x_reg <= item_reg.start_x; pss_y_reg <= item_reg.start_y;
                pse_x_reg <= item_reg.end_x;   pse_y_reg <= item_reg.end_y;
                lo_x_reg  <= res.cur_x;        lo_y_reg  <= res.cur_y;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        f_reg    <= f_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dc_reg   <= dc_next;
        rs_reg   <= rs_next;
        ts_reg   <= ts_next;
        re_reg   <= re_next;
        te_reg   <= te_next;
        if (pv_we)
        begin
            out_reg <= res;
        end
    end

    assign in_ready  = (st_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        st_next = st_reg;
        item_next = item_reg;
        f_next = f_reg; q_next = q_reg; rem_next = rem_reg; dc_next = dc_reg;
        rs_next = rs_reg; ts_next = ts_reg;
        re_next = re_reg; te_next = te_reg;
        cs = 1'b0; cvec = 1'b0; cxi = '0; cyi = '0; cai = '0;
        pv_we = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    q_next    = QW'(in_data.frame_index) << BLEND_BITS;
                    rem_next  = '0;
                    dc_next   = '0;
                    st_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (rem_sh >= {2'b0, fc_eff})
                begin
                    rem_next = 11'(rem_sh - {2'b0, fc_eff});
                    q_next   = {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[10:0];
                    q_next   = {q_reg[QW-2:0], 1'b0};
                end
                dc_next = dc_reg + 1'b1;
                if (dc_reg == DCW'(QW - 1))
                begin
                    st_next = ST_EASE_INIT;
                end
            end
            ST_EASE_INIT:
            begin
                f_next = q_reg[FW-1:0];
                if (item_reg.frame_index == 10'd0)
                begin
                    f_next  = '0;
                    st_next = ST_POLAR_S_INIT;
                end
                else if (item_reg.frame_index >= fc_eff)
                begin
                    f_next  = ONE;
                    st_next = ST_POLAR_S_INIT;
                end
                else if (ease_mode_reg == EASE_IN || ease_mode_reg == EASE_OUT)
                begin
                    cs  = 1'b1;
                    cxi = VW'(ONE) <<< FRAC;
                    cai = ease_ang;
                    st_next = ST_EASE_RUN;
                end
                else
                begin
                    st_next = ST_POLAR_S_INIT;
                end
            end
            ST_EASE_RUN:
            begin
                if (cdone)
                begin
                    f_next  = FW'(fe);
                    st_next = ST_POLAR_S_INIT;
                end
            end
            ST_POLAR_S_INIT:
            begin
                if (interp_mode_reg && !item_reg.first_vertex)
                begin
                    cs = 1'b1; cvec = 1'b1; cxi = dsx; cyi = dsy;
                    st_next = ST_POLAR_RUN;
                end
                else
                begin
                    st_next = ST_OUT;
                end
            end
            ST_POLAR_RUN:
            begin
                if (cdone)
                begin
                    rs_next = cxo;
                    ts_next = cao;
                    st_next = ST_POLAR_E_INIT;
                end
            end
            ST_POLAR_E_INIT:
            begin
                cs = 1'b1; cvec = 1'b1; cxi = dex; cyi = dey;
                st_next = ST_POLAR_E_DONE;
            end
            ST_POLAR_E_DONE:
            begin
                if (cdone)
                begin
                    re_next = cxo;
                    te_next = cao;
                    st_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                rs_next = r_blend;
                ts_next = th;
                st_next = ST_ROT_INIT;
            end
            ST_ROT_INIT:
            begin
                cs = 1'b1; cxi = rs_reg; cai = ts_reg;
                st_next = ST_ROT_DONE;
            end
            ST_ROT_DONE:
            begin
                // rotation result stays in the unit until the output frees up
                if (cdone)
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        pv_we   = 1'b1;
                        st_next = ST_IDLE;
                    end
                    else
                    begin
                        st_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    pv_we   = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        pv_we |-> (!out_valid_reg || out_ready))
        else $error("output overwritten");

endmodule

// File: tb/sv/smi_checker.sv
// smi_checker: predicts every tweened vertex of the shape morph interpolator
// and compares it field by field with the output channel. Depends on smi_pkg.
`timescale 1ns / 1ps
module smi_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  smi_pkg::smi_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  smi_pkg::smi_out_t out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [9:0]        cfg_data,
    output int                fail_count,
    output int                pending
);
    import smi_pkg::*;

    localparam int ABITS = 16;
    localparam int BBITS = 12;
    localparam int FRACB = 12;
    localparam longint ONE = 64'sd1 << BBITS;
    localparam longint TURN = 64'sd1 << ABITS;
    localparam longint HALF = TURN >> 1;
    localparam longint QUART = TURN >> 2;
    localparam longint KGAIN = 64'sd652032874;

    logic [9:0] frames;
    logic [1:0] ease;
    logic       vec_mode;
    longint     prev_st [2];
    longint     prev_en [2];
    longint     prev_out [2];
    smi_out_t   vertex_q [$];
    int         vertex_cnt;

    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint tshr(longint v, int n);
        if (v >= 0)
            return v >>> n;
        return -((-v) >>> n);
    endfunction

    function automatic longint atan_entry(int i);
        logic [31:0] t;
        t = atan_turn32(i[4:0]);
        return longint'((t + 32'h8000) >> 16);
    endfunction

    task automatic vectoring(input longint xi, input longint yi,
                             output longint r, output longint ang);
        longint x, y, z, nx, ny;
        x = xi; y = yi; z = 0;
        if (x == 0 && y == 0)
        begin
            r = 0; ang = 0;
            return;
        end
        if (x < 0)
        begin
            x = -x; y = -y; z = HALF;
        end
        for (int i = 0; i < ABITS; i++)
        begin
            if (y > 0)
            begin
                nx = x + fshr(y, i); ny = y - fshr(x, i); z += atan_entry(i);
            end
            else
            begin
                nx = x - fshr(y, i); ny = y + fshr(x, i); z -= atan_entry(i);
            end
            x = nx; y = ny;
        end
        r = fshr(x * KGAIN, 30);
        ang = z & (TURN - 1);
    endtask

    task automatic rotation(input longint mag, input longint ang,
                            output longint cx, output longint cy);
        longint x, y, z, nx, ny;
        x = fshr(mag * KGAIN, 30); y = 0; z = ang & (TURN - 1);
        if (z >= QUART && z < 3 * QUART)
        begin
            x = -x; z -= HALF;
        end
        if (z >= HALF)
            z -= TURN;
        for (int i = 0; i < ABITS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - fshr(y, i); ny = y + fshr(x, i); z -= atan_entry(i);
            end
            else
            begin
                nx = x + fshr(y, i); ny = y - fshr(x, i); z += atan_entry(i);
            end
            x = nx; y = ny;
        end
        cx = x; cy = y;
    endtask

    task automatic eased_factor(input logic [9:0] idx, output longint f);
        longint fc, t, a, c, s;
        fc = (frames == 0) ? 1 : frames;
        if (idx == 0)
            f = 0;
        else if (idx >= fc)
            f = ONE;
        else
        begin
            t = (longint'(idx) << BBITS) / fc;
            if (ease != EASE_IN && ease != EASE_OUT)
                f = t;
            else
            begin
                a = (t << (ABITS - 2)) >> BBITS;
                rotation(ONE << FRACB, a, c, s);
                if (ease == EASE_IN)
                    f = ONE - fshr(c, FRACB);
                else
                    f = fshr(s, FRACB);
                if (f < 0) f = 0;
                if (f > ONE) f = ONE;
            end
        end
    endtask

    task automatic predict_vertex(input smi_in_t it);
        longint f, rs, ts, re, te, d, r, th, v;
        longint st [2];
        longint en [2];
        longint res [2];
        longint seg [2];
        smi_out_t o;
        o.saturated = 1'b0;
        eased_factor(it.frame_index, f);
        st[0] = it.start_x; st[1] = it.start_y;
        en[0] = it.end_x;   en[1] = it.end_y;
        if (!vec_mode || it.first_vertex)
        begin
            for (int k = 0; k < 2; k++)
                res[k] = ((ONE - f) * st[k] + f * en[k]) >>> BBITS;
        end
        else
        begin
            vectoring((st[0] - prev_st[0]) <<< FRACB, (st[1] - prev_st[1]) <<< FRACB, rs, ts);
            vectoring((en[0] - prev_en[0]) <<< FRACB, (en[1] - prev_en[1]) <<< FRACB, re, te);
            d = te - ts;
            if (d > HALF)
                d -= TURN;
            else if (d < -HALF)
                d += TURN;
            th = (ts + fshr(f * d, BBITS)) & (TURN - 1);
            r = ((ONE - f) * rs + f * re) >>> BBITS;
            rotation(r, th, seg[0], seg[1]);
            for (int k = 0; k < 2; k++)
            begin
                v = tshr((prev_out[k] <<< FRACB) + seg[k], FRACB);
                if (v > 2047 || v < -2048) o.saturated = 1'b1;
                res[k] = (v > 2047) ? 2047 : ((v < -2048) ? -2048 : v);
            end
        end
        for (int k = 0; k < 2; k++)
        begin
            prev_st[k] = st[k]; prev_en[k] = en[k]; prev_out[k] = res[k];
        end
        o.cur_x = res[0][11:0];
        o.cur_y = res[1][11:0];
        vertex_q.push_back(o);
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch at vertex %0d: %s", $realtime, vertex_cnt, what);
        fail_count++;
    endtask

    assign pending = vertex_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        smi_out_t want;
        if (!rst_n)
        begin
            frames = 10'd20; ease = EASE_LINEAR; vec_mode = 1'b0;
            for (int k = 0; k < 2; k++)
            begin
                prev_st[k] = 0; prev_en[k] = 0; prev_out[k] = 0;
            end
            vertex_q.delete();
            fail_count = 0;
            vertex_cnt = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_COUNT: frames = cfg_data;
                    REG_EASE_MODE:   ease = cfg_data[1:0];
                    REG_INTERP_MODE: vec_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_vertex(in_data);
            if (out_valid && out_ready)
            begin
                if (vertex_q.size() == 0)
                    report_mismatch("output with nothing expected");
                else
                begin
                    want = vertex_q.pop_front();
                    if (out_data.cur_x !== want.cur_x)
                        report_mismatch($sformatf("cur_x %0d want %0d",
                                                  out_data.cur_x, want.cur_x));
                    if (out_data.cur_y !== want.cur_y)
                        report_mismatch($sformatf("cur_y %0d want %0d",
                                                  out_data.cur_y, want.cur_y));
                    if (out_data.saturated !== want.saturated)
                        report_mismatch($sformatf("saturated %0b want %0b",
                                                  out_data.saturated, want.saturated));
                end
                vertex_cnt++;
            end
        end
    end
endmodule

// File: tb/sv/shape_morph_interpolator_tb.sv
// shape_morph_interpolator_tb: drives polylines through the interpolator across
// frame counts, easing curves and blend modes. Depends on smi_pkg, smi_checker.
`timescale 1ns / 1ps
module shape_morph_interpolator_tb;
    import smi_pkg::*;

    localparam int STALL_LIMIT = 20000;   // cycles with no handshake at all

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    smi_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    smi_out_t out_data;
    logic     cfg_we;
    logic [1:0] cfg_index;
    logic [9:0] cfg_data;
    int       fail_count;
    int       pending;

    // idle percentages for each side, changed per phase
    int       send_idle_pct;
    int       recv_idle_pct;
    logic     hold_recv;          // long receiver hold-off request
    int       items_sent;
    int       idle_cycles;

    shape_morph_interpolator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    smi_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold while hold_recv is set
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_recv)
            begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_recv = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run when nothing is accepted for too long
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else if (++idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Offer one vertex; valid stays high until accepted and drops only
    // when the sender idles or stops
    task automatic send_vertex(input smi_in_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic smi_in_t rand_vertex(input logic [9:0] idx, input logic first);
        smi_in_t v;
        v.frame_index  = idx;
        v.first_vertex = first;
        v.start_x = 11'($urandom); v.start_y = 11'($urandom);
        v.end_x   = 11'($urandom); v.end_y   = 11'($urandom);
        return v;
    endfunction

    // Wait for every expected vertex, then let any tail work settle
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input logic [9:0] fc, input logic [1:0] em, input logic im);
        drain();
        write_reg(REG_FRAME_COUNT, fc);
        write_reg(REG_EASE_MODE, em);
        write_reg(REG_INTERP_MODE, {9'd0, im});
    endtask

    // A polyline of one frame: first vertex then a run of segments.
    // Occasionally a broken one that starts without the first-vertex mark.
    task automatic send_polyline(input int nverts, input logic [9:0] fc);
        logic [9:0] idx;
        logic       broken;
        broken = ($urandom_range(9) == 0);
        case ($urandom_range(5))
            0: idx = 10'd0;
            1: idx = fc;
            2: idx = 10'($urandom);
            default: idx = 10'($urandom_range(fc));
        endcase
        for (int i = 0; i < nverts; i++)
            send_vertex(rand_vertex(idx, (i == 0) && !broken));
    endtask

    logic [9:0] fc_set [8] = '{10'd1, 10'd1023, 10'd20, 10'd0, 10'd7, 10'd300, 10'd64, 10'd2};

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0; in_data = '0;
        cfg_we = 1'b0; cfg_index = REG_FRAME_COUNT; cfg_data = '0;
        send_idle_pct = 0; recv_idle_pct = 0;
        hold_recv = 1'b0;
        items_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset config (linear blend), a step with no first vertex, coordinate extremes
        send_vertex('{10'd5, 1'b0, 11'd2047, 11'd0, 11'd0, 11'd2047});
        send_vertex('{10'd0, 1'b1, 11'd0, 11'd0, 11'd2047, 11'd2047});
        send_vertex('{10'd20, 1'b0, 11'd2047, 11'd2047, 11'd0, 11'd0});
        send_vertex('{10'd1023, 1'b0, 11'd1023, 11'd1024, 11'd1024, 11'd1023});
        configure(10'd20, EASE_LINEAR, 1'b1);
        // vector step with no first vertex after config, zero-length segment,
        // half-turn angle differences and a run toward saturation
        send_vertex('{10'd10, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0});
        send_vertex('{10'd10, 1'b0, 11'd0, 11'd0, 11'd0, 11'd0});
        send_vertex('{10'd10, 1'b1, 11'd100, 11'd100, 11'd100, 11'd100});
        send_vertex('{10'd10, 1'b0, 11'd200, 11'd100, 11'd0, 11'd100});
        send_vertex('{10'd10, 1'b0, 11'd200, 11'd200, 11'd0, 11'd0});
        send_vertex('{10'd20, 1'b1, 11'd2047, 11'd2047, 11'd2047, 11'd2047});
        send_vertex('{10'd30, 1'b0, 11'd0, 11'd2047, 11'd2047, 11'd0});
        send_vertex('{10'd15, 1'b0, 11'd2047, 11'd0, 11'd0, 11'd2047});
        send_vertex('{10'd7, 1'b0, 11'd0, 11'd0, 11'd2047, 11'd2047});
        configure(10'd0, 2'd3, 1'b0);       // zero frame count, unused ease code
        send_vertex('{10'd0, 1'b1, 11'd5, 11'd6, 11'd7, 11'd8});
        send_vertex('{10'd1, 1'b0, 11'd5, 11'd6, 11'd2000, 11'd8});
        configure(10'd1023, EASE_IN, 1'b0);
        send_vertex('{10'd1, 1'b0, 11'd0, 11'd2047, 11'd2047, 11'd0});
        send_vertex('{10'd512, 1'b0, 11'd0, 11'd2047, 11'd2047, 11'd0});
        send_vertex('{10'd1022, 1'b0, 11'd0, 11'd2047, 11'd2047, 11'd0});
        configure(10'd1023, EASE_OUT, 1'b1);
        send_vertex('{10'd1, 1'b1, 11'd0, 11'd2047, 11'd2047, 11'd0});
        send_vertex('{10'd600, 1'b0, 11'd1000, 11'd1, 11'd3, 11'd1500});
        send_vertex('{10'd1022, 1'b0, 11'd40, 11'd1900, 11'd1200, 11'd2});

        // Random phases: each picks a setting and an idling pattern
        for (int ph = 0; ph < 16; ph++)
        begin
            logic [9:0] fc;
            fc = fc_set[ph % 8];
            configure(fc, 2'(ph % 4), ph[0] ^ ph[2]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 61; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 61; end
                default: begin send_idle_pct = 22; recv_idle_pct = 22; end
            endcase
            if (ph == 5)
                hold_recv = 1'b1;   // block fills while the sender keeps offering
            for (int n = 0; n < 90; )
            begin
                int len;
                len = $urandom_range(8, 1);
                if ($urandom_range(7) == 0)
                begin
                    len = 1;        // noise
                    send_vertex(rand_vertex(10'($urandom), 1'($urandom_range(1))));
                end
                else
                    send_polyline(len, (fc == 0) ? 10'd1 : fc);
                n += len;
                if (ph == 9 && n > 40 && n <= 48)
                    drain();            // sender waits for every vertex to come back
            end
        end

        drain();
        $display("covered %0d vertices over 16 random phases plus directed cases,",
                 items_sent);
        $display("all three ease curves, both blend modes and frame counts 0..1023");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
